[hdl/grr_pkg.sv]
// ----------------------------------------------------------------------------
// grr_pkg: shared types and constants of the glyph row rasterizer
// Field widths, font geometry limits, opcodes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package grr_pkg;

  // Font geometry (font byte count and slot count are powers of two)
  localparam int FONT_BYTES      = 4096;
  localparam int MAX_CELL_HEIGHT = 32;
  localparam int MAX_CELL_WIDTH  = 32;
  localparam int GLYPH_SLOTS     = 256;

  // Request and result field widths
  localparam int MODE_W = 3;
  localparam int CODE_W = 8;
  localparam int ADDR_W = 12;
  localparam int VAL_W  = 12;
  localparam int X_W    = 10;
  localparam int Y_W    = 9;
  localparam int PIX_W  = 32;
  localparam int WID_W  = 6;

  localparam int FA_W      = $clog2(FONT_BYTES);
  localparam int GS_W      = $clog2(GLYPH_SLOTS);
  localparam int H_W       = $clog2(MAX_CELL_HEIGHT + 1);
  localparam int RUN_LIMIT = (MAX_CELL_WIDTH < PIX_W) ? MAX_CELL_WIDTH : PIX_W;

  // Bitmap bytes that one run of visible columns can span
  localparam int WIN_BYTES = (RUN_LIMIT + 6) / 8 + 1;
  localparam int WIN_W     = 8 * WIN_BYTES;
  localparam int T_W       = $clog2(WIN_W);
  localparam int NB_W      = $clog2(WIN_BYTES + 1);
  localparam int B_W       = (WIN_BYTES > 1) ? $clog2(WIN_BYTES) : 1;

  // Request queue
  localparam int Q_DEPTH = 4;
  localparam int Q_W     = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_CHAR_SPACING    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_COLORS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_BACKGROUND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_CODE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_COUNT      = 3'd5;

  localparam logic [3:0] RST_CHAR_SPACING    = 4'd1;
  localparam logic       RST_INVERT_COLORS   = 1'b0;
  localparam logic       RST_FILL_BACKGROUND = 1'b1;
  localparam logic [5:0] RST_FONT_HEIGHT     = 6'd17;
  localparam logic [7:0] RST_BASE_CODE       = 8'd32;
  localparam logic [8:0] RST_CHAR_COUNT      = 9'd95;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_LOAD_FONT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_OFS   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET_CURSOR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DRAW       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MEASURE    = 3'd4;

  typedef enum logic [2:0] {
    OP_FONT,
    OP_OFS,
    OP_CURSOR,
    OP_DRAW,
    OP_MEASURE,
    OP_MISS
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] index;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    logic [X_W-1:0]    pos_x;
    logic [Y_W-1:0]    pos_y;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic [3:0] char_spacing;
    logic       invert_colors;
    logic       fill_background;
    logic [5:0] font_height;
    logic [7:0] base_code;
    logic [8:0] char_count;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFS,
    ST_HDR,
    ST_SETUP1,
    ST_SETUP2,
    ST_ROW,
    ST_FETCH,
    ST_DRAIN,
    ST_EMIT
  } st_t;

  // Ones in the low n bits
  function automatic logic [PIX_W-1:0] low_mask(input logic [WID_W-1:0] n);
    return ~({PIX_W{1'b1}} << n);
  endfunction

endpackage

[hdl/grr_if.sv]
// ----------------------------------------------------------------------------
// grr_if: request and result channels of the glyph row rasterizer
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface grr_in_if;
  import grr_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CODE_W-1:0] char_code;
  logic [ADDR_W-1:0] font_addr;
  logic [VAL_W-1:0]  load_value;
  logic [X_W-1:0]    pos_x;
  logic [Y_W-1:0]    pos_y;

  modport source (
    output valid, mode, char_code, font_addr, load_value, pos_x, pos_y,
    input  ready
  );
  modport sink (
    input  valid, mode, char_code, font_addr, load_value, pos_x, pos_y,
    output ready
  );
endinterface

interface grr_out_if;
  import grr_pkg::*;

  logic             valid;
  logic             ready;
  logic [Y_W-1:0]   row_y;
  logic [X_W-1:0]   row_x;
  logic [PIX_W-1:0] row_pixels;
  logic [PIX_W-1:0] row_mask;
  logic [WID_W-1:0] row_width;
  logic             last_row;

  modport source (
    output valid, row_y, row_x, row_pixels, row_mask, row_width, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_y, row_x, row_pixels, row_mask, row_width, last_row,
    output ready
  );
endinterface

[hdl/grr_front.sv]
// ----------------------------------------------------------------------------
// grr_front: request intake and classification
// Decodes each request, resolves glyph lookups and queues the work in order.
// ----------------------------------------------------------------------------
module grr_front (
  input  logic            clk,
  input  logic            rst,
  input  grr_pkg::cfg_t   cfg,
  grr_in_if.sink          cmd,
  output grr_pkg::q_head_t head,
  input  logic            pop
);
  import grr_pkg::*;

  cmd_t            q_mem [Q_DEPTH];
  logic [Q_W-1:0]  wr_ptr;
  logic [Q_W-1:0]  rd_ptr;
  logic [QC_W-1:0] count;

  cmd_t            entry;
  logic            keep;
  logic            push;
  logic [CODE_W:0] idx_ext;
  logic            miss;

  always_comb begin
    idx_ext = {1'b0, cmd.char_code} - {1'b0, cfg.base_code};
    miss = (cmd.char_code < cfg.base_code) || (idx_ext >= cfg.char_count) ||
           (idx_ext >= (CODE_W + 1)'(GLYPH_SLOTS));

    entry.op    = OP_FONT;
    entry.index = cmd.char_code;
    entry.addr  = cmd.font_addr;
    entry.value = cmd.load_value;
    entry.pos_x = cmd.pos_x;
    entry.pos_y = cmd.pos_y;
    keep        = 1'b1;

    unique case (cmd.mode)
      MODE_LOAD_FONT: entry.op = OP_FONT;
      MODE_LOAD_OFS: begin
        entry.op = OP_OFS;
        // drop loads beyond the offset table
        keep = ({1'b0, cmd.char_code} < (CODE_W + 1)'(GLYPH_SLOTS));
      end
      MODE_SET_CURSOR: entry.op = OP_CURSOR;
      MODE_DRAW: begin
        entry.op    = miss ? OP_MISS : OP_DRAW;
        entry.index = idx_ext[CODE_W-1:0];
      end
      MODE_MEASURE: begin
        entry.op    = miss ? OP_MISS : OP_MEASURE;
        entry.index = idx_ext[CODE_W-1:0];
      end
      default: keep = 1'b0;
    endcase
  end

  assign cmd.ready  = (count != QC_W'(Q_DEPTH));
  assign push       = cmd.valid && cmd.ready && keep;
  assign head.valid = (count != '0);
  assign head.cmd   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_W'(1);
      end
      if (push && !pop) begin
        count <= count + QC_W'(1);
      end else if (!push && pop) begin
        count <= count - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry;
    end
  end

endmodule

[hdl/grr_back.sv]
// ----------------------------------------------------------------------------
// grr_back: glyph sequencer and row generator
// Owns the font and offset stores and the cursor; turns queued work into rows.
// ----------------------------------------------------------------------------
module grr_back (
  input  logic             clk,
  input  logic             rst,
  input  grr_pkg::cfg_t    cfg,
  input  grr_pkg::q_head_t head,
  output logic             pop,
  grr_out_if.source        rows
);
  import grr_pkg::*;

  st_t state, state_next;

  // Stores
  logic [7:0]       font_mem [FONT_BYTES];
  logic [VAL_W-1:0] ofs_mem  [GLYPH_SLOTS];
  logic [7:0]       font_rdata;
  logic [VAL_W-1:0] ofs_rdata;
  logic [FA_W-1:0]  font_raddr;
  logic             font_we;
  logic             ofs_we;

  // Cursor
  logic [X_W-1:0] cursor_x;
  logic [Y_W-1:0] cursor_y;

  // Glyph header and derived geometry
  logic             is_measure;
  logic [1:0]       hc;
  logic [FA_W-1:0]  off;
  logic [7:0]       cx, cy, cols, rows_n;
  logic [H_W-1:0]   h;
  logic [WID_W-1:0] w;
  logic [5:0]       nb;
  logic [WID_W-1:0] ncol, padw;
  logic [PIX_W-1:0] wmask, padmask, cmask;
  logic [NB_W-1:0]  nbr;
  logic [T_W-1:0]   t;
  logic [FA_W-1:0]  rbase;

  // Row walk
  logic [H_W-1:0]   r;
  logic             fetched;
  logic [B_W-1:0]   b;
  logic             cap_valid;
  logic [B_W-1:0]   cap_b;
  logic [WIN_W-1:0] win;

  // Output register
  logic             out_valid;
  logic [Y_W-1:0]   o_y;
  logic [X_W-1:0]   o_x;
  logic [PIX_W-1:0] o_pix, o_mask;
  logic [WID_W-1:0] o_width;
  logic             o_last;

  logic slot_free;
  logic emit_row;
  logic emit_one;
  logic glyph_row;
  logic last_c;

  // Setup arithmetic
  logic [8:0]       tot;
  logic [WID_W-1:0] ncol_c, padw_c;
  logic [7:0]       kmin;
  logic [4:0]       jlo_c, jhi_c;
  logic [NB_W-1:0]  nbr_c;
  logic [T_W-1:0]   t_c;
  logic [PIX_W-1:0] wmask_c, padmask_c;

  // Pixel assembly
  logic [WIN_W-1:0] rev, sh;
  logic [PIX_W-1:0] gbits, gmask, pix_c, mask_c;
  logic             color;

  assign slot_free = !out_valid || rows.ready;
  assign glyph_row = (9'(r) >= 9'(cy)) && ((9'(r) - 9'(cy)) < 9'(rows_n));
  assign last_c    = (r == h - H_W'(1));

  // Sequencer
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    font_we    = 1'b0;
    ofs_we     = 1'b0;
    font_raddr = rbase + FA_W'(b);
    emit_row   = 1'b0;
    emit_one   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          unique case (head.cmd.op) inside
            OP_FONT:             font_we = 1'b1;
            OP_OFS:              ofs_we = 1'b1;
            OP_DRAW, OP_MEASURE: state_next = ST_OFS;
            OP_MISS:             state_next = ST_EMIT;
            default: ;
          endcase
        end
      end
      ST_OFS: begin
        font_raddr = FA_W'(ofs_rdata);
        state_next = ST_HDR;
      end
      ST_HDR: begin
        font_raddr = off + FA_W'(hc) + FA_W'(1);
        if (hc == 2'd3) begin
          state_next = is_measure ? ST_EMIT : ST_SETUP1;
        end
      end
      ST_SETUP1: state_next = ST_SETUP2;
      ST_SETUP2: state_next = ST_ROW;
      ST_ROW: begin
        if (glyph_row && (ncol != '0) && !fetched) begin
          state_next = ST_FETCH;
        end else if (slot_free) begin
          emit_row = 1'b1;
          if (last_c) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FETCH: begin
        font_raddr = rbase + FA_W'(b);
        if (b == B_W'(nbr - NB_W'(1))) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_ROW;
      ST_EMIT: begin
        if (slot_free) begin
          emit_one   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Geometry of the visible columns
  always_comb begin
    tot       = 9'(cx) + 9'(cols);
    ncol_c    = (9'(w) > 9'(cx)) ? WID_W'(9'(w) - 9'(cx)) : '0;
    padw_c    = (9'(cx) < 9'(w)) ? WID_W'(cx) : w;
    kmin      = cols - 8'(ncol_c);
    jlo_c     = kmin[7:3];
    jhi_c     = 5'((cols - 8'd1) >> 3);
    nbr_c     = NB_W'(jhi_c - jlo_c) + NB_W'(1);
    t_c       = T_W'(cols - 8'd1 - {jlo_c, 3'b000});
    wmask_c   = low_mask(w);
    padmask_c = low_mask(padw_c);
  end

  // Reverse the fetched bytes so the leftmost glyph column lands at bit 0
  always_comb begin
    for (int i = 0; i < WIN_W; i++) begin
      rev[i] = win[WIN_W-1-i];
    end
    sh    = rev >> (T_W'(WIN_W - 1) - t);
    gbits = PIX_W'(sh) << padw;
    color = !cfg.invert_colors;
    gmask = cmask & (cfg.fill_background ? {PIX_W{1'b1}} : gbits);
    if (glyph_row) begin
      pix_c  = (color ? padmask : '0) | (gmask & (color ? ~gbits : gbits));
      mask_c = padmask | gmask;
    end else begin
      pix_c  = color ? wmask : '0;
      mask_c = wmask;
    end
  end

  // Font store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[FA_W'(head.cmd.addr)] <= head.cmd.value[7:0];
    end
    font_rdata <= font_mem[font_raddr];
  end

  // Offset table
  always_ff @(posedge clk) begin
    if (ofs_we) begin
      ofs_mem[head.cmd.index[GS_W-1:0]] <= head.cmd.value;
    end
    ofs_rdata <= ofs_mem[head.cmd.index[GS_W-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x  <= '0;
      cursor_y  <= '0;
      fetched   <= 1'b0;
      cap_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cap_valid <= (state == ST_FETCH);
      if (state == ST_IDLE && head.valid && head.cmd.op == OP_CURSOR) begin
        cursor_x <= head.cmd.pos_x;
        cursor_y <= head.cmd.pos_y;
      end
      if (state == ST_HDR && hc == 2'd3 && is_measure) begin
        cursor_x <= cursor_x + X_W'(cx) + X_W'(cols);
      end
      if (emit_row && last_c) begin
        cursor_x <= cursor_x + X_W'(cx) + X_W'(cols) + X_W'(cfg.char_spacing);
      end
      if (state == ST_DRAIN) begin
        fetched <= 1'b1;
      end else if (emit_row) begin
        fetched <= 1'b0;
      end
      if (emit_row || emit_one) begin
        out_valid <= 1'b1;
      end else if (rows.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cap_b <= b;
    if (cap_valid) begin
      win[{cap_b, 3'b000} +: 8] <= font_rdata;
    end
    if (state == ST_IDLE) begin
      is_measure <= (head.cmd.op == OP_MEASURE);
      hc         <= '0;
    end
    if (state == ST_OFS) begin
      off <= FA_W'(ofs_rdata);
    end
    if (state == ST_HDR) begin
      case (hc)
        2'd0:    cx <= font_rdata;
        2'd1:    cy <= font_rdata;
        2'd2:    cols <= font_rdata;
        default: rows_n <= font_rdata;
      endcase
      hc <= hc + 2'd1;
    end
    if (state == ST_SETUP1) begin
      if (cfg.font_height == '0) begin
        h <= H_W'(1);
      end else if (int'(cfg.font_height) > MAX_CELL_HEIGHT) begin
        h <= H_W'(MAX_CELL_HEIGHT);
      end else begin
        h <= H_W'(cfg.font_height);
      end
      w  <= (tot < 9'(RUN_LIMIT)) ? WID_W'(tot) : WID_W'(RUN_LIMIT);
      nb <= 6'((9'(cols) + 9'd7) >> 3);
      r  <= '0;
    end
    if (state == ST_SETUP2) begin
      ncol    <= ncol_c;
      padw    <= padw_c;
      wmask   <= wmask_c;
      padmask <= padmask_c;
      cmask   <= wmask_c & ~padmask_c;
      nbr     <= nbr_c;
      t       <= t_c;
      rbase   <= off + FA_W'(4) + FA_W'(jlo_c);
    end
    if (state == ST_ROW) begin
      b <= '0;
    end else if (state == ST_FETCH) begin
      b <= b + B_W'(1);
    end
    if (emit_row) begin
      r <= r + H_W'(1);
      if (glyph_row) begin
        rbase <= rbase + FA_W'(nb);
      end
      o_y     <= cursor_y + Y_W'(r);
      o_x     <= cursor_x;
      o_pix   <= pix_c;
      o_mask  <= mask_c;
      o_width <= w;
      o_last  <= last_c;
    end else if (emit_one) begin
      o_y     <= cursor_y;
      o_x     <= cursor_x;
      o_pix   <= '0;
      o_mask  <= '0;
      o_width <= '0;
      o_last  <= 1'b1;
    end
  end

  assign rows.valid      = out_valid;
  assign rows.row_y      = o_y;
  assign rows.row_x      = o_x;
  assign rows.row_pixels = o_pix;
  assign rows.row_mask   = o_mask;
  assign rows.row_width  = o_width;
  assign rows.last_row   = o_last;

endmodule

[hdl/glyph_row_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// glyph_row_rasterizer_top: proportional bitmap font renderer, one row a result
// Configuration registers, request front end, queue and glyph sequencer.
// ----------------------------------------------------------------------------
// Load the font bytes and glyph offsets with load requests, place the cursor,
// then send draw or measure requests; a draw returns one row per font line,
// last_row marking the final one. A draw looks up the glyph offset and header
// and runs setup, then builds each padding row directly and, for each glyph
// row, fetches the nbytes (1 to 5) bitmap bytes under the visible columns
// one at a time through the single read port of the font store. A four-entry
// request queue lets intake run ahead of the sequencer, and an output
// register lets the next row be built while the current one waits. The font
// store and offset table hold no reset value and need no clearing pass.
// ----------------------------------------------------------------------------
module glyph_row_rasterizer_top (
  input  logic                             clk,
  input  logic                             rst,
  grr_in_if.sink                           cmd,
  grr_out_if.source                        rows,
  input  logic                             cfg_we,
  input  logic [grr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [grr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import grr_pkg::*;

  cfg_t    cfg;
  q_head_t head;
  logic    pop;

  // Hold config; the user writes it only while no request is in flight, unchecked
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.char_spacing    <= RST_CHAR_SPACING;
      cfg.invert_colors   <= RST_INVERT_COLORS;
      cfg.fill_background <= RST_FILL_BACKGROUND;
      cfg.font_height     <= RST_FONT_HEIGHT;
      cfg.base_code       <= RST_BASE_CODE;
      cfg.char_count      <= RST_CHAR_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHAR_SPACING:    cfg.char_spacing <= cfg_data[3:0];
        REG_INVERT_COLORS:   cfg.invert_colors <= cfg_data[0];
        REG_FILL_BACKGROUND: cfg.fill_background <= cfg_data[0];
        REG_FONT_HEIGHT:     cfg.font_height <= cfg_data[5:0];
        REG_BASE_CODE:       cfg.base_code <= cfg_data[7:0];
        REG_CHAR_COUNT:      cfg.char_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Accept, classify and queue requests
  grr_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .cmd  (cmd),
    .head (head),
    .pop  (pop)
  );

  // Walk glyphs and drive the result channel
  grr_back u_back (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .head (head),
    .pop  (pop),
    .rows (rows)
  );

  // The sequencer takes work only from a filled queue slot
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("queue popped while empty");

  // No result is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rows.valid)
    else $error("result offered after reset");

  // Written pixels stay inside the run
  a_mask_in_run: assert property (@(posedge clk) disable iff (rst)
    rows.valid |-> ((rows.row_mask & ~low_mask(rows.row_width)) == '0))
    else $error("write mask extends past the run width");

  // Pixel bits appear only where the mask writes
  a_pix_in_mask: assert property (@(posedge clk) disable iff (rst)
    rows.valid |-> ((rows.row_pixels & ~rows.row_mask) == '0))
    else $error("pixel bit set outside the write mask");

endmodule

[test/glyph_row_rasterizer_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_row_rasterizer_top_test: self-checking bench for the glyph rasterizer
// Builds small proportional glyphs in the font store and draws or measures
// them under several register settings. An internal row predictor checks
// every result row, including wide, tall, padded, wrapped and out-of-font
// characters. Both handshakes are randomly throttled until the last phases.
// ----------------------------------------------------------------------------
module glyph_row_rasterizer_top_test;
  import grr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_REQS     = 22;
  localparam int REPORT_CAP     = 200;

  // Modes the block ignores
  localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

  // One request as the bench sees it, and one rasterized row
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CODE_W-1:0] code;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    logic [X_W-1:0]    px;
    logic [Y_W-1:0]    py;
  } text_req_t;

  typedef struct packed {
    logic [Y_W-1:0]   y;
    logic [X_W-1:0]   x;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] mask;
    logic [WID_W-1:0] width;
    logic             last;
  } pixel_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grr_in_if  cmd_ch ();
  grr_out_if row_ch ();

  glyph_row_rasterizer_top uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rows      (row_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register values as the block holds them; written only while it is idle
  cfg_t cfg_now = '{RST_CHAR_SPACING, RST_INVERT_COLORS, RST_FILL_BACKGROUND,
                    RST_FONT_HEIGHT, RST_BASE_CODE, RST_CHAR_COUNT};

  // Predictor state, advanced as requests are accepted
  logic [7:0]     font_mem [FONT_BYTES];
  logic [VAL_W-1:0] ofs_mem [GLYPH_SLOTS];
  logic [X_W-1:0] cur_x = '0;
  logic [Y_W-1:0] cur_y = '0;
  pixel_row_t     expected_rows [$];

  // Generator view of the store, advanced as requests are queued; it keeps
  // draws away from glyphs that would read never-written bytes
  logic [7:0]       gen_font [FONT_BYTES];
  bit               gen_written [FONT_BYTES];
  logic [VAL_W-1:0] gen_ofs [GLYPH_SLOTS];
  bit               gen_ofs_set [GLYPH_SLOTS];
  int               defined_slots [$];
  int               next_font_ofs = FONT_BYTES - 2;

  text_req_t pending_reqs [$];
  text_req_t held_req;
  int reqs_issued      = 0;
  int reqs_counted     = 0;
  int reqs_accepted    = 0;
  int rows_checked     = 0;
  int settings_applied = 0;
  int errors           = 0;
  int quiet_cycles     = 0;
  int send_idle_pct    = 0;
  int recv_idle_pct    = 0;

  // --------------------------------------------------------------------------
  // Row predictor
  // --------------------------------------------------------------------------
  function automatic logic [7:0] store_byte(input int a);
    return font_mem[a % FONT_BYTES];
  endfunction

  // Cell height after clamping the register to the supported range
  function automatic int cell_rows();
    if (cfg_now.font_height == 0) return 1;
    if (cfg_now.font_height > MAX_CELL_HEIGHT) return MAX_CELL_HEIGHT;
    return int'(cfg_now.font_height);
  endfunction

  task automatic rasterize_request(input text_req_t q);
    int slot, gofs, pad, top, cols, nrows, nb, w, padw, h, base, k, col, r, c;
    logic             bg;
    logic [7:0]       bits8;
    logic [63:0]      wide;
    logic [PIX_W-1:0] run_mask, pad_mask;
    pixel_row_t       row;
    case (q.mode)
      MODE_LOAD_FONT: font_mem[q.addr] = q.value[7:0];
      MODE_LOAD_OFS:  ofs_mem[q.code] = q.value;
      MODE_SET_CURSOR: begin
        cur_x = q.px;
        cur_y = q.py;
      end
      MODE_DRAW, MODE_MEASURE: begin
        slot = int'(q.code) - int'(cfg_now.base_code);
        row = '0;
        row.y = cur_y;
        row.x = cur_x;
        row.last = 1'b1;
        if (slot < 0 || slot >= int'(cfg_now.char_count) || slot >= GLYPH_SLOTS) begin
          // outside the font: one empty closing row, cursor stays put
          expected_rows.push_back(row);
        end else begin
          gofs  = int'(ofs_mem[slot]);
          pad   = int'(store_byte(gofs));
          top   = int'(store_byte(gofs + 1));
          cols  = int'(store_byte(gofs + 2));
          nrows = int'(store_byte(gofs + 3));
          if (q.mode == MODE_MEASURE) begin
            cur_x = X_W'(int'(cur_x) + pad + cols);
            row.x = cur_x;
            expected_rows.push_back(row);
          end else begin
            h    = cell_rows();
            nb   = (cols + 7) / 8;
            w    = (pad + cols < RUN_LIMIT) ? pad + cols : RUN_LIMIT;
            padw = (pad < w) ? pad : w;
            wide = (64'd1 << w) - 64'd1;
            run_mask = wide[PIX_W-1:0];
            wide = (64'd1 << padw) - 64'd1;
            pad_mask = wide[PIX_W-1:0];
            bg = !cfg_now.invert_colors;
            for (r = 0; r < h; r++) begin
              row.y = Y_W'(int'(cur_y) + r);
              row.x = cur_x;
              row.width = WID_W'(w);
              row.last = (r == h - 1);
              if (r < top || r - top >= nrows) begin
                row.pix  = bg ? run_mask : '0;
                row.mask = run_mask;
              end else begin
                base = gofs + 4 + (r - top) * nb;
                row.pix  = bg ? pad_mask : '0;
                row.mask = pad_mask;
                for (c = 0; c < cols && pad + c < w; c++) begin
                  k     = cols - 1 - c;
                  col   = pad + c;
                  bits8 = store_byte(base + k / 8);
                  if (bits8[k % 8] || cfg_now.fill_background) begin
                    row.mask[col] = 1'b1;
                    if (bits8[k % 8] != bg) row.pix[col] = 1'b1;
                  end
                end
              end
              expected_rows.push_back(row);
            end
            cur_x = X_W'(int'(cur_x) + pad + cols + int'(cfg_now.char_spacing));
          end
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic text_req_t rand_req(input logic [MODE_W-1:0] m);
    text_req_t q;
    q.mode  = m;
    q.code  = CODE_W'($urandom);
    q.addr  = ADDR_W'($urandom);
    q.value = VAL_W'($urandom);
    q.px    = X_W'($urandom);
    q.py    = Y_W'($urandom);
    return q;
  endfunction

  task automatic push_req(input text_req_t q);
    case (q.mode)
      MODE_LOAD_FONT: begin
        gen_font[q.addr]    = q.value[7:0];
        gen_written[q.addr] = 1'b1;
      end
      MODE_LOAD_OFS: begin
        gen_ofs[q.code]     = q.value;
        gen_ofs_set[q.code] = 1'b1;
      end
      default: ;
    endcase
    if (q.mode <= MODE_MEASURE) reqs_counted++;
    reqs_issued++;
    pending_reqs.push_back(q);
  endtask

  task automatic queue_glyph_op(input logic [MODE_W-1:0] m, input int code);
    text_req_t q;
    q = rand_req(m);
    q.code = CODE_W'(code);
    push_req(q);
  endtask

  // True when drawing or measuring this code reads only written bytes
  function automatic bit glyph_readable(input int code);
    int slot, gofs, top, cols, nrows, nb, h, r, b;
    slot = code - int'(cfg_now.base_code);
    if (slot < 0 || slot >= int'(cfg_now.char_count) || slot >= GLYPH_SLOTS) return 1'b1;
    if (!gen_ofs_set[slot]) return 1'b0;
    gofs = int'(gen_ofs[slot]);
    for (b = 0; b < 4; b++)
      if (!gen_written[(gofs + b) % FONT_BYTES]) return 1'b0;
    top   = int'(gen_font[(gofs + 1) % FONT_BYTES]);
    cols  = int'(gen_font[(gofs + 2) % FONT_BYTES]);
    nrows = int'(gen_font[(gofs + 3) % FONT_BYTES]);
    nb = (cols + 7) / 8;
    h  = cell_rows();
    for (r = top; r < h && r < top + nrows; r++)
      for (b = 0; b < nb; b++)
        if (!gen_written[(gofs + 4 + (r - top) * nb + b) % FONT_BYTES]) return 1'b0;
    return 1'b1;
  endfunction

  // Mostly codes of glyphs already built, sometimes any code at all
  function automatic int pick_code();
    int c, tries;
    for (tries = 0; tries < 8; tries++) begin
      if (defined_slots.size() == 0 || $urandom_range(0, 4) == 0)
        c = $urandom_range(0, 255);
      else
        c = int'(cfg_now.base_code) +
            defined_slots[$urandom_range(0, defined_slots.size() - 1)];
      if (c <= 255 && glyph_readable(c)) return c;
    end
    if (cfg_now.base_code > 0) return 0;
    if (cfg_now.char_count < 256) return 255;
    return -1;
  endfunction

  // Write header, bitmap rows and the slot's offset as load requests
  task automatic put_glyph(input int slot, input int pad, input int top, input int cols,
                           input int nrows);
    int hdr [4];
    int i, nb, base;
    text_req_t q;
    hdr  = '{pad, top, cols, nrows};
    nb   = (cols + 7) / 8;
    base = next_font_ofs;
    for (i = 0; i < 4 + nrows * nb; i++) begin
      q = rand_req(MODE_LOAD_FONT);
      q.addr = ADDR_W'((base + i) % FONT_BYTES);
      if (i < 4) q.value[7:0] = 8'(hdr[i]);
      push_req(q);
    end
    q = rand_req(MODE_LOAD_OFS);
    q.code  = CODE_W'(slot);
    q.value = VAL_W'(base);
    push_req(q);
    next_font_ofs = (base + 4 + nrows * nb) % FONT_BYTES;
    defined_slots.push_back(slot);
  endtask

  task automatic add_random_glyph();
    int kind, top_slot;
    top_slot = (cfg_now.char_count == 0) ? 0 :
               (cfg_now.char_count > GLYPH_SLOTS) ? GLYPH_SLOTS - 1 :
               int'(cfg_now.char_count) - 1;
    if ($urandom_range(0, 9) == 0) top_slot = GLYPH_SLOTS - 1;
    kind = $urandom_range(0, 9);
    if (kind == 0)        // often wider than the run: columns get clipped
      put_glyph($urandom_range(0, top_slot), $urandom_range(0, 8), $urandom_range(0, 3),
                $urandom_range(25, 48), $urandom_range(1, 3));
    else if (kind == 1)   // pad fills most of the run, few or no bitmap columns
      put_glyph($urandom_range(0, top_slot), $urandom_range(28, 40), $urandom_range(0, 2),
                $urandom_range(0, 3), $urandom_range(1, 3));
    else
      put_glyph($urandom_range(0, top_slot), $urandom_range(0, 5), $urandom_range(0, 6),
                $urandom_range(1, 12), $urandom_range(1, 10));
  endtask

  // Wait until every request is in and every row is out, then let it settle
  task automatic settle();
    do @(posedge clk);
    while (reqs_accepted != reqs_issued || expected_rows.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_CHAR_SPACING:    cfg_now.char_spacing    = val[3:0];
      REG_INVERT_COLORS:   cfg_now.invert_colors   = val[0];
      REG_FILL_BACKGROUND: cfg_now.fill_background = val[0];
      REG_FONT_HEIGHT:     cfg_now.font_height     = val[5:0];
      REG_BASE_CODE:       cfg_now.base_code       = val[7:0];
      REG_CHAR_COUNT:      cfg_now.char_count      = val[8:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int spacing, input int invert, input int fill,
                                input int height, input int first, input int count);
    write_reg(REG_CHAR_SPACING, spacing);
    write_reg(REG_INVERT_COLORS, invert);
    write_reg(REG_FILL_BACKGROUND, fill);
    write_reg(REG_FONT_HEIGHT, height);
    write_reg(REG_BASE_CODE, first);
    write_reg(REG_CHAR_COUNT, count);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request driver: hold a request until accepted, then advance to the next
  // one or idle at the current sender rate
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid      <= 1'b0;
      cmd_ch.mode       <= '0;
      cmd_ch.char_code  <= '0;
      cmd_ch.font_addr  <= '0;
      cmd_ch.load_value <= '0;
      cmd_ch.pos_x      <= '0;
      cmd_ch.pos_y      <= '0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        rasterize_request(held_req);
        reqs_accepted++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          held_req = pending_reqs.pop_front();
          cmd_ch.valid      <= 1'b1;
          cmd_ch.mode       <= held_req.mode;
          cmd_ch.char_code  <= held_req.code;
          cmd_ch.font_addr  <= held_req.addr;
          cmd_ch.load_value <= held_req.value;
          cmd_ch.pos_x      <= held_req.px;
          cmd_ch.pos_y      <= held_req.py;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Row monitor: compare each accepted row with the oldest expected one and
  // drop ready at the current receiver rate
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_row_t got, want;
    if (rst) begin
      row_ch.ready <= 1'b0;
    end else begin
      if (row_ch.valid && row_ch.ready) begin
        got = '{row_ch.row_y, row_ch.row_x, row_ch.row_pixels, row_ch.row_mask,
                row_ch.row_width, row_ch.last_row};
        rows_checked++;
        if (expected_rows.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: unexpected row, expected none, actual y=%0d x=%0d pix=0x%08h",
                     $time, got.y, got.x, got.pix);
        end else begin
          want = expected_rows.pop_front();
          check_field("row_y", want.y, got.y);
          check_field("row_x", want.x, got.x);
          check_field("row_pixels", want.pix, got.pix);
          check_field("row_mask", want.mask, got.mask);
          check_field("row_width", want.width, got.width);
          check_field("last_row", want.last, got.last);
        end
      end
      row_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Give up when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (row_ch.valid && row_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles, %0d rows still expected",
               $time, quiet_cycles, expected_rows.size());
      $display("glyph_row_rasterizer_top_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int ph, goal, pick, c;
    text_req_t q;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: codes below and beyond the font,
    // a glyph whose header wraps the end of the store, a glyph wider than
    // the run, cursor wrap on both axes, measure, and the unused modes
    send_idle_pct = 21;
    recv_idle_pct = 51;
    queue_glyph_op(MODE_DRAW, 0);
    queue_glyph_op(MODE_MEASURE, 200);
    put_glyph(0, 2, 1, 8, 3);
    put_glyph(1, 3, 0, 40, 1);
    q = rand_req(MODE_SET_CURSOR);
    q.px = '1;
    q.py = '1;
    push_req(q);
    queue_glyph_op(MODE_DRAW, 32);
    queue_glyph_op(MODE_MEASURE, 33);
    queue_glyph_op(MODE_DRAW, 33);
    push_req(rand_req(MODE_SPARE_LO));
    push_req(rand_req(MODE_SPARE_MID));
    push_req(rand_req(MODE_SPARE_HI));
    queue_glyph_op(MODE_DRAW, 127);

    // Random phases, each under its own register setting; the first ones
    // hit the extremes, including heights outside the supported range
    for (ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: apply_settings(15, 1, 0, 32, 0, 256);
        1: apply_settings(0, 0, 0, 0, 16, 200);
        2: apply_settings(7, 1, 1, 63, 32, 95);
        3: apply_settings(3, 0, 1, 1, 255, 1);
        4: apply_settings(1, 1, 0, 8, 0, 0);
        default: apply_settings($urandom_range(0, 15), $urandom_range(0, 1),
                                $urandom_range(0, 1), $urandom_range(1, 32),
                                $urandom_range(0, 48), $urandom_range(1, 256));
      endcase
      if (ph < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 51;
      end else if (ph < 6) begin
        send_idle_pct = 51;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // Build a couple of fresh glyphs, then mostly draw with some noise
      add_random_glyph();
      add_random_glyph();
      goal = reqs_counted + PHASE_REQS;
      while (reqs_counted < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
          c = pick_code();
          if (c >= 0) queue_glyph_op((pick < 55) ? MODE_DRAW : MODE_MEASURE, c);
        end else if (pick < 76) begin
          push_req(rand_req(MODE_SET_CURSOR));
        end else if (pick < 82) begin
          push_req(rand_req(MODE_LOAD_FONT));
        end else if (pick < 86) begin
          push_req(rand_req(MODE_LOAD_OFS));
        end else if (pick < 90) begin
          push_req(rand_req(MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))));
        end else begin
          add_random_glyph();
        end
      end
    end

    settle();
    if (expected_rows.size() != 0) begin
      errors += expected_rows.size();
      $display("%0t: %0d rows expected but never produced", $time, expected_rows.size());
    end
    $display("Covered %0d requests and %0d result rows over %0d register settings,",
             reqs_accepted, rows_checked, settings_applied + 1);
    $display("with %0d glyphs built and %0d mismatches.", defined_slots.size(), errors);
    if (errors == 0) begin
      $display("glyph_row_rasterizer_top_test: clean");
    end else begin
      $display("glyph_row_rasterizer_top_test: errors");
    end
    $finish;
  end

endmodule
